[rtl/tfdp_pkg.sv]
// Shared types, constants and helpers for the thermal fan duty policy block.
package tfdp_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int TEMP_W       = 19;
  localparam int DUTY_W       = 7;
  localparam int LIMIT_W      = 32;
  localparam int CFG_IDX_W    = 4;
  localparam int CMP_W        = TEMP_W + 1;

  localparam int IN_BITS    = SENSOR_COUNT * TEMP_W + 1 + SENSOR_COUNT;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = DUTY_W + 2 + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DUTY_W-1:0] DUTY_CAP       = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_LOW_RST   = 7'd40;
  localparam logic [DUTY_W-1:0] DUTY_MID_RST   = 7'd70;
  localparam logic [DUTY_W-1:0] DUTY_HIGH_RST  = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MID  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH = 4'd2;
  localparam int                   CFG_LIMIT0    = 3;

  // bytes from low end: lower1, upper1, lower2, upper2 (whole degrees)
  localparam logic [LIMIT_W-1:0] LIMIT_RESET [8] = '{
    32'h3D38342F, 32'h3B36322D, 32'h423D3A35, 32'h3A35302B,
    32'h55504B46, 32'h0, 32'h0, 32'h0
  };

  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_MID  = 2'd1,
    LVL_HIGH = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_FAN    = 2'd1,
    FAULT_SENSOR = 2'd2
  } fault_t;

  typedef struct packed {
    logic any_up1;
    logic any_up2;
    logic all_lo1;
    logic all_lo2;
  } tfdp_flags_t;

  // whole degrees to millicelsius, as a signed compare operand
  function automatic logic signed [CMP_W-1:0] limit_mc(input logic [7:0] deg);
    logic [17:0] mc;
    mc = 18'(deg) * 18'd1000;
    return signed'({2'b00, mc});
  endfunction

endpackage

[rtl/tfdp_sense.sv]
// Per-sensor threshold compares reduced to the four hysteresis flags.
module tfdp_sense
  import tfdp_pkg::*;
(
  input  logic [SENSOR_COUNT-1:0][TEMP_W-1:0]  temps,
  input  logic [SENSOR_COUNT-1:0][LIMIT_W-1:0] limits,
  output tfdp_flags_t                          flags
);

  logic [SENSOR_COUNT-1:0] up1, up2, ge_lo1, ge_lo2;

  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      logic signed [CMP_W-1:0] t;
      t = signed'({temps[i][TEMP_W-1], temps[i]});
      up1[i]    = t >  limit_mc(limits[i][15:8]);
      up2[i]    = t >  limit_mc(limits[i][31:24]);
      ge_lo1[i] = t >= limit_mc(limits[i][7:0]);
      ge_lo2[i] = t >= limit_mc(limits[i][23:16]);
    end
    flags.any_up1 = |up1;
    flags.any_up2 = |up2;
    flags.all_lo1 = ~|ge_lo1;
    flags.all_lo2 = ~|ge_lo2;
  end

endmodule

[rtl/thermal_fan_duty_policy.sv]
// Top level of the thermal fan duty policy: poll register, level update, result register.
//
// Usage:
//   in_*  : one poll per transaction, five temperatures, fan health and a
//           read-valid mask packed in in_tdata.
//   out_* : one result per poll: duty percent, new fan level, fault code.
//   cfg_* : write-only register port (duty per level, per-sensor limits),
//           written while no poll is in flight.
// Path: an accepted poll is held in the poll register, then in the result
//   register, whose valid bit drives out_tvalid.
// Throughput: one poll per cycle while out_tready is high; the level register is
//   updated as a poll moves into the result register, so the next poll sees the new level.
// Stall: when out_tready is low the result holds, the poll register keeps
//   one more poll, and in_tready drops only when both are full.
// Reset (rst_n low, synchronous): level goes to low, duties and limits take
//   their default values, both stages empty.
module thermal_fan_duty_policy
  import tfdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // temp_0..temp_4 (19b each), fans_ok, temp_valid (5b), zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // duty_percent (7b), fan_level (2b), fault (2b), zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [LIMIT_W-1:0]    cfg_wdata
);

  logic [DUTY_W-1:0] duty_low_r, duty_mid_r, duty_high_r;
  logic [SENSOR_COUNT-1:0][LIMIT_W-1:0] limits_r;

  logic                                in_v_r;
  logic [SENSOR_COUNT-1:0][TEMP_W-1:0] temps_r;
  logic                                fans_ok_r;
  logic [SENSOR_COUNT-1:0]             tvalid_r;

  logic              out_v_r;
  logic [DUTY_W-1:0] out_duty_r;
  level_t            out_level_r;
  fault_t            out_fault_r;

  level_t level_r, level_nxt;
  fault_t fault_nxt;
  logic [DUTY_W-1:0] duty_sel, duty_nxt;
  tfdp_flags_t flags;
  logic advance, in_acc;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_low_r  <= DUTY_LOW_RST;
      duty_mid_r  <= DUTY_MID_RST;
      duty_high_r <= DUTY_HIGH_RST;
      for (int i = 0; i < SENSOR_COUNT; i++) limits_r[i] <= LIMIT_RESET[i];
    end else if (cfg_we) begin
      if (cfg_addr == CFG_DUTY_LOW)  duty_low_r  <= cfg_wdata[DUTY_W-1:0];
      if (cfg_addr == CFG_DUTY_MID)  duty_mid_r  <= cfg_wdata[DUTY_W-1:0];
      if (cfg_addr == CFG_DUTY_HIGH) duty_high_r <= cfg_wdata[DUTY_W-1:0];
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (cfg_addr == CFG_IDX_W'(CFG_LIMIT0 + i)) limits_r[i] <= cfg_wdata;
      end
    end
  end

  // poll register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < SENSOR_COUNT; i++) temps_r[i] <= in_tdata[i*TEMP_W +: TEMP_W];
      fans_ok_r <= in_tdata[SENSOR_COUNT*TEMP_W];
      tvalid_r  <= in_tdata[SENSOR_COUNT*TEMP_W+1 +: SENSOR_COUNT];
    end
  end

  tfdp_sense u_sense (
    .temps  (temps_r),
    .limits (limits_r),
    .flags  (flags)
  );

  always_comb begin
    if (!fans_ok_r) begin
      fault_nxt = FAULT_FAN;
    end else if (!(&tvalid_r)) begin
      fault_nxt = FAULT_SENSOR;
    end else begin
      fault_nxt = FAULT_NONE;
    end

    if (fault_nxt != FAULT_NONE) begin
      level_nxt = LVL_HIGH;
    end else begin
      unique case (level_r)
        LVL_LOW:  level_nxt = flags.any_up1 ? LVL_MID : LVL_LOW;
        LVL_MID:  level_nxt = flags.any_up2 ? LVL_HIGH :
                              (flags.all_lo1 ? LVL_LOW : LVL_MID);
        LVL_HIGH: level_nxt = flags.all_lo2 ? LVL_MID : LVL_HIGH;
        default:  level_nxt = LVL_LOW; // lost level falls back to low
      endcase
    end

    unique case (level_nxt)
      LVL_LOW:  duty_sel = duty_low_r;
      LVL_MID:  duty_sel = duty_mid_r;
      default:  duty_sel = duty_high_r;
    endcase
    duty_nxt = (duty_sel > DUTY_CAP) ? DUTY_CAP : duty_sel;
  end

  // level and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_LOW;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        level_r <= level_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty_r  <= duty_nxt;
      out_level_r <= level_nxt;
      out_fault_r <= fault_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_BITS)'(0), out_fault_r, out_level_r, out_duty_r};

`ifndef SYNTHESIS
  a_fault_forces_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_fault_r == FAULT_NONE || out_level_r == LVL_HIGH))
    else $error("fault result without high level");

  a_duty_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_duty_r <= DUTY_CAP))
    else $error("duty above cap");

  a_level_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (level_r == out_level_r))
    else $error("level register differs from last result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_v_r && !out_tready))
    else $error("input stalled with room available");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the thermal fan duty policy block.
`timescale 1ns / 100ps

module testbench;
  import tfdp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_IDX_W'(CFG_LIMIT0 + SENSOR_COUNT);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;

  typedef struct {
    logic [SENSOR_COUNT-1:0][TEMP_W-1:0] temp;
    logic                                fans_ok;
    logic [SENSOR_COUNT-1:0]             temp_valid;
  } poll_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    level_t            lvl;
    fault_t            flt;
  } fan_result_t;

  // Tracks level and registers; holds the duty/level/fault each poll should produce.
  class fan_policy_sb;
    level_t            level;
    logic [DUTY_W-1:0] duty [3];
    logic [LIMIT_W-1:0] limits [SENSOR_COUNT];
    fan_result_t       pending_q [$];
    int errors, n_polls, n_results, n_fan_fault, n_sensor_fault;
    int n_level [3];

    function void reset_model();
      level   = LVL_LOW;
      duty[0] = DUTY_LOW_RST;
      duty[1] = DUTY_MID_RST;
      duty[2] = DUTY_HIGH_RST;
      for (int i = 0; i < SENSOR_COUNT; i++) limits[i] = LIMIT_RESET[i];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] v);
      if (idx == CFG_DUTY_LOW) duty[0] = v[DUTY_W-1:0];
      else if (idx == CFG_DUTY_MID) duty[1] = v[DUTY_W-1:0];
      else if (idx == CFG_DUTY_HIGH) duty[2] = v[DUTY_W-1:0];
      else if (int'(idx) < CFG_LIMIT0 + SENSOR_COUNT) limits[int'(idx) - CFG_LIMIT0] = v;
    endfunction

    // byte k of a limit word, whole degrees to millicelsius
    function int deg_mc(logic [LIMIT_W-1:0] lim, int k);
      return int'(lim[8*k +: 8]) * 1000;
    endfunction

    function void note_poll(poll_t p);
      fan_result_t r;
      bit any_up1, any_up2, all_lo1, all_lo2;
      int t;
      any_up1 = 0; any_up2 = 0; all_lo1 = 1; all_lo2 = 1;
      n_polls++;
      if (!p.fans_ok) r.flt = FAULT_FAN;
      else if (p.temp_valid != '1) r.flt = FAULT_SENSOR;
      else r.flt = FAULT_NONE;
      if (r.flt != FAULT_NONE) begin
        level = LVL_HIGH;
      end else begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          t = int'(signed'(p.temp[i]));
          if (t > deg_mc(limits[i], 1)) any_up1 = 1;
          if (t > deg_mc(limits[i], 3)) any_up2 = 1;
          if (t >= deg_mc(limits[i], 0)) all_lo1 = 0;
          if (t >= deg_mc(limits[i], 2)) all_lo2 = 0;
        end
        case (level)
          LVL_LOW:  level = any_up1 ? LVL_MID : LVL_LOW;
          LVL_MID:  level = any_up2 ? LVL_HIGH : (all_lo1 ? LVL_LOW : LVL_MID);
          LVL_HIGH: level = all_lo2 ? LVL_MID : LVL_HIGH;
          default:  level = LVL_LOW; // lost level falls back to low
        endcase
      end
      r.lvl = level;
      if (level == LVL_LOW) r.duty = duty[0];
      else if (level == LVL_MID) r.duty = duty[1];
      else r.duty = duty[2];
      if (r.duty > DUTY_CAP) r.duty = DUTY_CAP;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      fan_result_t e;
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with no poll outstanding: %h", d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.flt == FAULT_FAN) n_fan_fault++;
      if (e.flt == FAULT_SENSOR) n_sensor_fault++;
      n_level[e.lvl]++;
      if (d[6:0] !== e.duty) begin
        $error("duty_percent: expected %0d, actual %0d", e.duty, d[6:0]);
        errors++;
      end
      if (d[8:7] !== e.lvl) begin
        $error("fan_level: expected %0d, actual %0d", e.lvl, d[8:7]);
        errors++;
      end
      if (d[10:9] !== e.flt) begin
        $error("fault: expected %0d, actual %0d", e.flt, d[10:9]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [LIMIT_W-1:0]    cfg_wdata = '0;

  fan_policy_sb sb = new();
  bit tx_gaps = 1;
  bit rx_stalls = 1;
  bit rx_hold = 0;
  int idle_cycles = 0;

  thermal_fan_duty_policy dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic poll_t uniform_poll(int t, logic ok, logic [SENSOR_COUNT-1:0] mask);
    poll_t p;
    for (int i = 0; i < SENSOR_COUNT; i++) p.temp[i] = TEMP_W'(t);
    p.fans_ok    = ok;
    p.temp_valid = mask;
    return p;
  endfunction

  // every sensor at its own threshold k plus an offset in millicelsius
  function automatic poll_t limit_poll(int k, int off);
    poll_t p;
    for (int i = 0; i < SENSOR_COUNT; i++)
      p.temp[i] = TEMP_W'(sb.deg_mc(sb.limits[i], k) + off);
    p.fans_ok    = 1'b1;
    p.temp_valid = '1;
    return p;
  endfunction

  // Mostly clustered around one threshold, most sensors on the same side, so that
  // the level walks through every transition; the rest is wide-range noise.
  function automatic poll_t rand_poll();
    poll_t p;
    int k, sgn, r, t;
    k   = $urandom_range(0, 3);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        t = sb.deg_mc(sb.limits[i], k);
        if ($urandom_range(0, 99) < 15) t = t - sgn * $urandom_range(0, 2500);
        else t = t + sgn * $urandom_range(0, 2500);
      end else if (r < 88) begin
        t = int'($urandom_range(0, 190000)) - 40000;
      end else begin
        t = int'($urandom);
      end
      p.temp[i] = TEMP_W'(t);
    end
    p.fans_ok    = ($urandom_range(0, 99) >= 5);
    p.temp_valid = ($urandom_range(0, 99) < 7) ? SENSOR_COUNT'($urandom) : '1;
    return p;
  endfunction

  function automatic logic [LIMIT_W-1:0] ordered_limits();
    logic [7:0] l1, u1, l2, u2;
    l1 = 8'($urandom_range(20, 120));
    u1 = l1 + 8'($urandom_range(1, 10));
    l2 = u1 + 8'($urandom_range(0, 10));
    u2 = l2 + 8'($urandom_range(1, 10));
    return {u2, l2, u1, l1};
  endfunction

  // called and returns just after a falling edge
  task automatic send_poll(poll_t p, int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({p.temp_valid, p.fans_ok, p.temp});
    do @(posedge clk); while (!in_tready);
    sb.note_poll(p);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_random(int n);
    repeat (n) send_poll(rand_poll(), tx_gaps ? gap_len() : 0);
  endtask

  // let every outstanding poll come back before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: random backpressure, plus one long hold-off on request
  int stall_left = 0;
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rx_hold = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_stalls) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sb.reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: threshold edges with default limits, faults, field extremes
    send_poll(uniform_poll(-40000, 1'b1, '1), gap_len());
    send_poll(limit_poll(1, 0), gap_len());     // equal to upper1: stay low
    send_poll(limit_poll(1, 1), gap_len());     // low -> mid
    send_poll(limit_poll(3, 0), gap_len());     // equal to upper2: stay mid
    send_poll(limit_poll(0, 0), gap_len());     // equal to lower1: stay mid
    send_poll(limit_poll(0, -1), gap_len());    // mid -> low
    send_poll(limit_poll(1, 1), gap_len());
    send_poll(limit_poll(3, 1), gap_len());     // mid -> high
    send_poll(limit_poll(2, 0), gap_len());     // equal to lower2: stay high
    send_poll(limit_poll(2, -1), gap_len());    // high -> mid
    send_poll(uniform_poll(262143, 1'b1, '1), gap_len());
    send_poll(uniform_poll(-262144, 1'b1, '1), gap_len());
    send_poll(uniform_poll(-262144, 1'b1, '1), gap_len());
    send_poll(uniform_poll(30000, 1'b0, '1), gap_len());  // fan fault
    send_poll(uniform_poll(30000, 1'b0, '0), gap_len());  // fan fault wins over read failure
    send_poll(uniform_poll(-40000, 1'b1, '1), gap_len());
    send_poll(uniform_poll(30000, 1'b1, 5'b11110), gap_len());
    send_poll(uniform_poll(30000, 1'b1, 5'b01111), gap_len());
    send_poll(uniform_poll(150000, 1'b1, '1), gap_len());
    send_poll(uniform_poll(150000, 1'b1, '0), gap_len());
    send_poll(uniform_poll(0, 1'b1, '1), gap_len());

    run_random(100);

    // duties of zero and above the cap, random limit words, writes to unused indexes, a long receiver hold
    drain();
    write_reg(CFG_DUTY_LOW, 32'h0);
    write_reg(CFG_DUTY_MID, {$urandom} | 32'h7F);
    write_reg(CFG_DUTY_HIGH, 32'd101);
    for (int i = 0; i < SENSOR_COUNT; i++)
      write_reg(CFG_IDX_W'(CFG_LIMIT0 + i), ($urandom_range(0, 1)) ? $urandom : ordered_limits());
    write_reg(CFG_UNUSED_FIRST, $urandom);
    write_reg(CFG_UNUSED_LAST, $urandom);
    run_random(50);
    rx_hold = 1;
    repeat (12) send_poll(rand_poll(), 0);
    run_random(40);

    // extreme limits, no idling on either side
    drain();
    tx_gaps   = 0;
    rx_stalls = 0;
    write_reg(CFG_DUTY_LOW, 32'(DUTY_CAP));
    write_reg(CFG_DUTY_MID, $urandom_range(0, 100));
    write_reg(CFG_DUTY_HIGH, 32'h0);
    write_reg(CFG_IDX_W'(CFG_LIMIT0), 32'h0);
    write_reg(CFG_IDX_W'(CFG_LIMIT0 + 1), 32'hFFFF_FFFF);
    for (int i = 2; i < SENSOR_COUNT; i++)
      write_reg(CFG_IDX_W'(CFG_LIMIT0 + i), ordered_limits());
    run_random(100);

    // back to the reset values
    drain();
    tx_gaps   = 1;
    rx_stalls = 1;
    write_reg(CFG_DUTY_LOW, 32'(DUTY_LOW_RST));
    write_reg(CFG_DUTY_MID, 32'(DUTY_MID_RST));
    write_reg(CFG_DUTY_HIGH, 32'(DUTY_HIGH_RST));
    for (int i = 0; i < SENSOR_COUNT; i++)
      write_reg(CFG_IDX_W'(CFG_LIMIT0 + i), LIMIT_RESET[i]);
    run_random(100);

    drain();
    $display("tb: %0d polls checked over four register settings, %0d fan faults, %0d read faults",
             sb.n_polls, sb.n_fan_fault, sb.n_sensor_fault);
    $display("tb: results at low/mid/high level: %0d/%0d/%0d",
             sb.n_level[0], sb.n_level[1], sb.n_level[2]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tfdp_pkg.sv
rtl/tfdp_sense.sv
rtl/thermal_fan_duty_policy.sv
tb/testbench.sv
